@@ hdl/ptde_pkg.sv @@
// Shared types, sizes and helpers for the polynomial trajectory derivative evaluator.
// No dependencies; every other file of the block imports this package.

package ptde_pkg;

    // Trajectory degree; powers above 7 have no storage
    localparam int DEGREE    = 7;
    localparam int PMAX      = (DEGREE < 7) ? DEGREE : 7;
    localparam int POW_SLOTS = 8;
    localparam int NUM_AXES  = 3;

    // Field widths
    localparam int MODE_W  = 1;
    localparam int ORD_W   = 3;
    localparam int TIME_W  = 32;
    localparam int AXIS_W  = 2;
    localparam int POW_W   = 3;
    localparam int COEFF_W = 32;
    localparam int VAL_W   = 48;

    // Datapath widths
    localparam int WGT_W      = 13;                  // up to 7! = 5040
    localparam int T_HALF     = TIME_W / 2;          // time split for two narrow multiplies
    localparam int TFRAC      = 24;                  // fraction bits of time
    localparam int PA_W       = VAL_W + T_HALF;
    localparam int FULL_W     = VAL_W + TIME_W;
    localparam int R_W        = FULL_W - TFRAC;
    localparam int CW_W       = COEFF_W + WGT_W + 1;
    localparam int TERM_SHIFT = 8;                   // Q16.16 -> Q24.24
    localparam int TERM_W     = CW_W + TERM_SHIFT;
    localparam int SUM_W      = R_W + 2;

    // Pipeline and queue shape
    localparam int STAGE_SUBS  = 4;                  // register stages per power
    localparam int QUEUE_DEPTH = 4;
    localparam int PEND_LIMIT  = QUEUE_DEPTH + POW_SLOTS * STAGE_SUBS + 1;

    localparam logic [MODE_W-1:0] MODE_EVAL  = 1'b0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        OP_EVAL,     // evaluate derivative at time
        OP_WRITE,    // store one coefficient
        OP_ZERO      // order above degree, result is all zero
    } op_t;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        op_t                        op;
        logic [ORD_W-1:0]           order;
        logic [TIME_W-1:0]          time_value;
        logic [AXIS_W-1:0]          axis;
        logic [POW_W-1:0]           power;
        logic signed [COEFF_W-1:0]  coeff;
    } item_t;

    // p!/(p-k)!, valid for k <= p <= 7
    function automatic logic [WGT_W-1:0] falling_weight(input int p,
                                                        input logic [ORD_W-1:0] k);
        int w;
        w = 1;
        for (int i = 0; i < POW_SLOTS - 1; i++) begin
            if (i < int'(k)) w = w * (p - i);
        end
        return WGT_W'(w);
    endfunction

endpackage

@@ hdl/ptde_front.sv @@
// Front end: input handshake, item classification and the short queue to the back end.
// Depends on ptde_pkg.

module ptde_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ptde_pkg::MODE_W-1:0]     s_mode,
    input  logic [ptde_pkg::ORD_W-1:0]      s_deriv_order,
    input  logic [ptde_pkg::TIME_W-1:0]     s_time_value,
    input  logic [ptde_pkg::AXIS_W-1:0]     s_axis_sel,
    input  logic [ptde_pkg::POW_W-1:0]      s_power_index,
    input  logic signed [ptde_pkg::COEFF_W-1:0] s_coeff_value,
    output logic                            q_valid,
    output ptde_pkg::item_t                 q_item,
    input  logic                            q_pop
);
    import ptde_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    item_t              item_in;
    logic               keep, push, pop;

    always_comb begin
        item_in.order      = s_deriv_order;
        item_in.time_value = s_time_value;
        item_in.axis       = s_axis_sel;
        item_in.power      = s_power_index;
        item_in.coeff      = s_coeff_value;
        if (s_mode == MODE_WRITE) begin
            item_in.op = OP_WRITE;
        end else if (int'(s_deriv_order) > PMAX) begin
            item_in.op = OP_ZERO;
        end else begin
            item_in.op = OP_EVAL;
        end
    end

    // writes to a nonexistent axis are dropped here
    assign keep    = !(s_mode == MODE_WRITE && int'(s_axis_sel) >= NUM_AXES);
    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = q_mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_next;
            if (pop)  rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wr_ptr_reg] <= item_in;
    end

endmodule

@@ hdl/ptde_horner.sv @@
// Back end: pipelined saturating Horner chain, one four-register stage per power,
// with each stage owning its coefficients, plus the result register. Depends on ptde_pkg.

module ptde_horner (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  ptde_pkg::item_t             q_item,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [ptde_pkg::VAL_W-1:0] m_x_value,
    output logic signed [ptde_pkg::VAL_W-1:0] m_y_value,
    output logic signed [ptde_pkg::VAL_W-1:0] m_z_value,
    output logic                        m_saturated
);
    import ptde_pkg::*;

    localparam logic [FULL_W-1:0] ROUND = FULL_W'(1) << (TFRAC - 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    logic   en;
    logic   st_vld [POW_SLOTS+1];
    item_t  st_ctl [POW_SLOTS+1];
    val_t   st_acc [POW_SLOTS+1][NUM_AXES];
    logic   st_sat [POW_SLOTS+1];

    logic   m_valid_reg, m_sat_reg;
    val_t   m_x_reg, m_y_reg, m_z_reg;

    // whole chain advances together; stalls only when the result register is held
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && q_valid;

    assign st_vld[0] = q_valid;
    assign st_ctl[0] = q_item;
    assign st_sat[0] = 1'b0;
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_acc0
        assign st_acc[0][a] = '0;
    end

    for (genvar g = 0; g < POW_SLOTS; g++) begin : g_pow
        localparam int P = POW_SLOTS - 1 - g;
        localparam logic [POW_W-1:0] P_IDX = POW_W'(P);
        localparam bit USED = (P <= PMAX);

        logic signed [COEFF_W-1:0]  coeff_reg [NUM_AXES];
        logic                       v1_reg, v2_reg, v3_reg, v4_reg;
        item_t                      c1_reg, c2_reg, c3_reg, c4_reg;
        logic                       sat1_reg, sat2_reg, sat3_reg, sat4_reg;
        val_t                       acc1_reg [NUM_AXES];
        val_t                       acc2_reg [NUM_AXES];
        val_t                       acc3_reg [NUM_AXES];
        val_t                       acc4_reg [NUM_AXES];
        logic [VAL_W-1:0]           mag1_reg [NUM_AXES];
        logic [WGT_W-1:0]           w1_reg;
        logic [PA_W-1:0]            pa2_reg [NUM_AXES];
        logic [PA_W-1:0]            pb2_reg [NUM_AXES];
        logic signed [CW_W-1:0]     cw2_reg [NUM_AXES];
        logic [R_W-1:0]             r3_reg [NUM_AXES];
        logic signed [TERM_W-1:0]   term3_reg [NUM_AXES];

        logic [FULL_W-1:0]          full [NUM_AXES];
        logic signed [SUM_W-1:0]    sum [NUM_AXES];
        val_t                       acc_new [NUM_AXES];
        logic [NUM_AXES-1:0]        clip;
        logic                       active;

        assign active = USED && v3_reg && (c3_reg.op == OP_EVAL) && (c3_reg.order <= P_IDX);

        always_comb begin
            for (int a = 0; a < NUM_AXES; a++) begin
                // |acc| * t rounded half up, back to Q24.24
                full[a] = {pa2_reg[a], {T_HALF{1'b0}}} + FULL_W'(pb2_reg[a]) + ROUND;
                // sign of acc is applied by choosing add or subtract
                if (acc3_reg[a][VAL_W-1]) begin
                    sum[a] = SUM_W'(term3_reg[a]) - $signed({2'b00, r3_reg[a]});
                end else begin
                    sum[a] = SUM_W'(term3_reg[a]) + $signed({2'b00, r3_reg[a]});
                end
                clip[a] = 1'b0;
                if (sum[a] > SUM_MAX) begin
                    acc_new[a] = VAL_MAX;
                    clip[a]    = 1'b1;
                end else if (sum[a] < SUM_MIN) begin
                    acc_new[a] = VAL_MIN;
                    clip[a]    = 1'b1;
                end else begin
                    acc_new[a] = sum[a][VAL_W-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
                v3_reg <= 1'b0;
                v4_reg <= 1'b0;
            end else if (en) begin
                v1_reg <= st_vld[g];
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                c1_reg   <= st_ctl[g];
                c2_reg   <= c1_reg;
                c3_reg   <= c2_reg;
                c4_reg   <= c3_reg;
                sat1_reg <= st_sat[g];
                sat2_reg <= sat1_reg;
                sat3_reg <= sat2_reg;
                sat4_reg <= sat3_reg | (active & (|clip));
                w1_reg   <= falling_weight(P, st_ctl[g].order);
                for (int a = 0; a < NUM_AXES; a++) begin
                    acc1_reg[a] <= st_acc[g][a];
                    mag1_reg[a] <= st_acc[g][a][VAL_W-1] ? VAL_W'(-st_acc[g][a])
                                                         : VAL_W'(st_acc[g][a]);
                    acc2_reg[a] <= acc1_reg[a];
                    pa2_reg[a]  <= PA_W'(mag1_reg[a])
                                   * PA_W'(c1_reg.time_value[TIME_W-1:T_HALF]);
                    pb2_reg[a]  <= PA_W'(mag1_reg[a])
                                   * PA_W'(c1_reg.time_value[T_HALF-1:0]);
                    cw2_reg[a]  <= CW_W'(coeff_reg[a]) * CW_W'($signed({1'b0, w1_reg}));
                    acc3_reg[a] <= acc2_reg[a];
                    r3_reg[a]   <= full[a][FULL_W-1:TFRAC];
                    term3_reg[a] <= {cw2_reg[a], {TERM_SHIFT{1'b0}}};
                    acc4_reg[a] <= active ? acc_new[a] : acc3_reg[a];
                    // write lands at the same place the evaluations read, keeping order
                    if (v1_reg && c1_reg.op == OP_WRITE && c1_reg.power == P_IDX
                        && c1_reg.axis == AXIS_W'(a)) begin
                        coeff_reg[a] <= c1_reg.coeff;
                    end
                end
            end
        end

        assign st_vld[g+1] = v4_reg;
        assign st_ctl[g+1] = c4_reg;
        assign st_sat[g+1] = sat4_reg;
        for (genvar a = 0; a < NUM_AXES; a++) begin : g_out
            assign st_acc[g+1][a] = acc4_reg[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= st_vld[POW_SLOTS] && (st_ctl[POW_SLOTS].op != OP_WRITE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_x_reg   <= st_acc[POW_SLOTS][0];
            m_y_reg   <= st_acc[POW_SLOTS][1];
            m_z_reg   <= st_acc[POW_SLOTS][2];
            m_sat_reg <= st_sat[POW_SLOTS];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_x_value   = m_x_reg;
    assign m_y_value   = m_y_reg;
    assign m_z_value   = m_z_reg;
    assign m_saturated = m_sat_reg;

endmodule

@@ hdl/poly_trajectory_derivative_eval_top.sv @@
// Top level of the polynomial trajectory derivative evaluator.
// Depends on ptde_pkg, ptde_front and ptde_horner.
//
// Usage:
//   Input channel s_*: with s_mode = 1 a beat stores one coefficient
//   (s_axis_sel, s_power_index, s_coeff_value) and gives no result; with
//   s_mode = 0 it evaluates derivative s_deriv_order of all three axes at
//   s_time_value and gives one result beat on m_*.
//   A coefficient write takes effect for every evaluation accepted after it.
//   A beat passes through the queue, then the 8-power Horner chain of
//   four register stages each, then the result register. Throughput: one
//   beat per cycle, writes included, while the receiver does not stall.
//   Reset: clears the queue, the pipeline valids and m_valid; coefficient
//   storage is not cleared and must be written before it is used.
//   Receiver stall: while m_valid is high and m_ready low the whole chain
//   holds; the 4-entry input queue keeps taking beats until it fills, then
//   s_ready drops.

module poly_trajectory_derivative_eval_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ptde_pkg::MODE_W-1:0]     s_mode,
    input  logic [ptde_pkg::ORD_W-1:0]      s_deriv_order,
    input  logic [ptde_pkg::TIME_W-1:0]     s_time_value,
    input  logic [ptde_pkg::AXIS_W-1:0]     s_axis_sel,
    input  logic [ptde_pkg::POW_W-1:0]      s_power_index,
    input  logic signed [ptde_pkg::COEFF_W-1:0] s_coeff_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ptde_pkg::VAL_W-1:0] m_x_value,
    output logic signed [ptde_pkg::VAL_W-1:0] m_y_value,
    output logic signed [ptde_pkg::VAL_W-1:0] m_z_value,
    output logic                            m_saturated
);
    import ptde_pkg::*;

    logic   q_valid;
    item_t  q_item;
    logic   q_pop;

    ptde_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_deriv_order (s_deriv_order),
        .s_time_value  (s_time_value),
        .s_axis_sel    (s_axis_sel),
        .s_power_index (s_power_index),
        .s_coeff_value (s_coeff_value),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    ptde_horner u_horner (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_x_value   (m_x_value),
        .m_y_value   (m_y_value),
        .m_z_value   (m_z_value),
        .m_saturated (m_saturated)
    );

endmodule

@@ hdl/ptde_checker.sv @@
// Port-level checker for the evaluator top level, attached by the bind at the end.
// Depends on ptde_pkg and poly_trajectory_derivative_eval_top.

module ptde_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [ptde_pkg::MODE_W-1:0]      s_mode,
    input logic                             m_valid,
    input logic                             m_ready
);
    import ptde_pkg::*;

    localparam int PEND_W = $clog2(PEND_LIMIT + 2);

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              eval_in, res_out;

    // evaluations accepted whose result beat has not gone out yet
    assign eval_in = s_valid && s_ready && (s_mode == MODE_EVAL);
    assign res_out = m_valid && m_ready;

    always_comb begin
        case ({eval_in, res_out})
            2'b10:   pend_next = pend_reg + 1'b1;
            2'b01:   pend_next = pend_reg - 1'b1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != '0)
        else $error("result beat without a pending evaluation");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PEND_W'(PEND_LIMIT))
        else $error("more evaluations in flight than the pipeline holds");

endmodule

bind poly_trajectory_derivative_eval_top ptde_checker u_checker (.*);

@@ tb/poly_trajectory_derivative_eval_top_tb.sv @@
// Self-checking testbench for poly_trajectory_derivative_eval_top: coefficient loads and
// derivative evaluations go through a valid/ready driver, and results are scored against
// a built-in Horner predictor. Depends on ptde_pkg and the block's RTL.
`timescale 1ns / 1ps

module poly_trajectory_derivative_eval_top_tb;

    import ptde_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int TOP_POW      = (DEGREE < 7) ? DEGREE : 7;
    localparam int RAND_BEATS   = 1670;
    localparam int IDLE_SPAN    = 150;
    localparam int HOLD_AT      = 300;   // result count that triggers the long back-pressure
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    localparam logic [ORD_W-1:0] ORD_POS  = 3'd0;
    localparam logic [ORD_W-1:0] ORD_VEL  = 3'd1;
    localparam logic [ORD_W-1:0] ORD_ACC  = 3'd2;
    localparam logic [ORD_W-1:0] ORD_JERK = 3'd3;
    localparam logic [ORD_W-1:0] ORD_SNAP = 3'd4;

    localparam logic [TIME_W-1:0] T_ZERO = '0;
    localparam logic [TIME_W-1:0] T_ONE  = 32'h0100_0000;
    localparam logic [TIME_W-1:0] T_MAX  = '1;

    localparam longint CLIP_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint CLIP_LO = -64'sh0000_8000_0000_0000;

    typedef enum int {
        CSTYLE_SMALL,
        CSTYLE_FULL,
        CSTYLE_EDGE
    } coeff_style_t;

    typedef struct {
        logic [MODE_W-1:0]          mode;
        logic [ORD_W-1:0]           order;
        logic [TIME_W-1:0]          tval;
        logic [AXIS_W-1:0]          axis;
        logic [POW_W-1:0]           power;
        logic signed [COEFF_W-1:0]  coeff;
        int                         gap;
        bit                         drain;
    } traj_beat_t;

    typedef struct {
        val_t x;
        val_t y;
        val_t z;
        logic sat;
    } traj_sample_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [MODE_W-1:0]          s_mode = MODE_EVAL;
    logic [ORD_W-1:0]           s_deriv_order = '0;
    logic [TIME_W-1:0]          s_time_value = '0;
    logic [AXIS_W-1:0]          s_axis_sel = '0;
    logic [POW_W-1:0]           s_power_index = '0;
    logic signed [COEFF_W-1:0]  s_coeff_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    val_t                       m_x_value;
    val_t                       m_y_value;
    val_t                       m_z_value;
    logic                       m_saturated;

    traj_beat_t                 stim_beats[$];
    traj_sample_t               pending_samples[$];
    logic signed [COEFF_W-1:0]  coeff_mem[NUM_AXES][POW_SLOTS];
    int                         err_cnt = 0;
    int                         results_seen = 0;
    bit                         gen_idle = 1'b1;
    bit                         gen_drain = 1'b0;

    poly_trajectory_derivative_eval_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_deriv_order (s_deriv_order),
        .s_time_value  (s_time_value),
        .s_axis_sel    (s_axis_sel),
        .s_power_index (s_power_index),
        .s_coeff_value (s_coeff_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_value     (m_x_value),
        .m_y_value     (m_y_value),
        .m_z_value     (m_z_value),
        .m_saturated   (m_saturated)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // Saturating Horner chain for one axis, highest power first.
    function automatic longint axis_derivative(int ax, int k, logic [TIME_W-1:0] t,
                                               inout bit clip);
        longint     acc;
        longint     prod;
        longint     term;
        longint     wgt;
        logic [95:0] mag;
        acc = 0;
        for (int p = TOP_POW; p >= k; p--) begin
            // |acc| * t rounded half away from zero, back to Q24.24
            mag  = (acc < 0) ? 96'(-acc) : 96'(acc);
            mag  = mag * t + (96'd1 << 23);
            prod = longint'(mag >> 24);
            if (acc < 0) prod = -prod;
            wgt = 1;
            for (int i = 0; i < k; i++) wgt = wgt * (p - i);
            term = longint'(coeff_mem[ax][p]) * wgt * 256;
            acc  = prod + term;
            if (acc > CLIP_HI) begin
                acc  = CLIP_HI;
                clip = 1'b1;
            end
            if (acc < CLIP_LO) begin
                acc  = CLIP_LO;
                clip = 1'b1;
            end
        end
        return acc;
    endfunction

    task automatic absorb_beat(input traj_beat_t b);
        traj_sample_t s;
        bit           clip;
        clip = 1'b0;
        if (b.mode == MODE_WRITE) begin
            if (b.axis != AXIS_NONE) coeff_mem[b.axis][b.power] = b.coeff;
        end else begin
            s.x   = val_t'(axis_derivative(0, b.order, b.tval, clip));
            s.y   = val_t'(axis_derivative(1, b.order, b.tval, clip));
            s.z   = val_t'(axis_derivative(2, b.order, b.tval, clip));
            s.sat = clip;
            pending_samples.push_back(s);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic queue_beat(input logic [MODE_W-1:0] mode, input logic [ORD_W-1:0] order,
                              input logic [TIME_W-1:0] tval, input logic [AXIS_W-1:0] axis,
                              input logic [POW_W-1:0] power, input logic [COEFF_W-1:0] coeff);
        traj_beat_t b;
        b.mode  = mode;
        b.order = order;
        b.tval  = tval;
        b.axis  = axis;
        b.power = power;
        b.coeff = coeff;
        b.gap   = gen_idle ? $urandom_range(0, 6) : 0;
        b.drain = gen_drain;
        gen_drain = 1'b0;
        stim_beats.push_back(b);
    endtask

    // unused fields of each kind of beat carry random junk
    task automatic queue_write(input logic [AXIS_W-1:0] axis, input logic [POW_W-1:0] power,
                               input logic [COEFF_W-1:0] coeff);
        queue_beat(MODE_WRITE, ORD_W'($urandom), $urandom, axis, power, coeff);
    endtask

    task automatic queue_eval(input logic [ORD_W-1:0] order, input logic [TIME_W-1:0] tval);
        queue_beat(MODE_EVAL, order, tval, AXIS_W'($urandom), POW_W'($urandom), $urandom);
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeff(coeff_style_t style);
        logic [COEFF_W-1:0] c;
        case (style)
            CSTYLE_SMALL: c = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            CSTYLE_FULL:  c = $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0:       c = 32'h7FFF_FFFF;
                    1:       c = 32'h8000_0000;
                    2:       c = '0;
                    3:       c = '1;
                    default: c = 32'h0001_0000;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        logic [TIME_W-1:0] t;
        case ($urandom_range(0, 7))
            0:       t = T_ZERO;
            1:       t = T_MAX;
            2, 3:    t = $urandom_range(0, T_ONE);
            4:       t = $urandom_range(0, 32'h0400_0000);
            default: t = $urandom;
        endcase
        return t;
    endfunction

    task automatic queue_segment(input coeff_style_t style);
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int p = 0; p < POW_SLOTS; p++) begin
                queue_write(AXIS_W'(a), POW_W'(p), pick_coeff(style));
            end
        end
    endtask

    task automatic build_stimulus();
        int n;
        int next_toggle;
        // directed: every entry loaded before the first evaluation, x and y with extremes
        for (int p = 0; p < POW_SLOTS; p++) begin
            queue_write(AXIS_X, POW_W'(p), 32'h7FFF_FFFF);
            queue_write(AXIS_Y, POW_W'(p), 32'h8000_0000);
            queue_write(AXIS_Z, POW_W'(p), COEFF_W'((p + 1) << 16));
        end
        queue_write(AXIS_NONE, 3'd7, '0);       // dropped write
        queue_eval(ORD_POS, T_MAX);
        queue_eval(ORD_VEL, T_MAX);
        queue_eval(ORD_ACC, T_MAX);
        queue_eval(ORD_JERK, T_MAX);
        queue_eval(ORD_SNAP, T_MAX);
        queue_eval(ORD_POS, T_ZERO);
        queue_eval(ORD_SNAP, T_ZERO);
        queue_eval(ORD_ACC, T_ONE);

        // random: segment reloads followed by sampling, with loose writes as noise
        gen_drain   = 1'b1;
        n           = 0;
        next_toggle = IDLE_SPAN;
        while (n < RAND_BEATS) begin
            if (n >= next_toggle) begin
                gen_idle    = !gen_idle;
                next_toggle = next_toggle + IDLE_SPAN;
            end
            if (n >= 1000 && n < 1010) gen_drain = 1'b1;
            if ($urandom_range(0, 15) == 0) begin
                queue_segment(coeff_style_t'($urandom_range(0, 2)));
                n = n + NUM_AXES * POW_SLOTS;
            end else if ($urandom_range(0, 3) == 0) begin
                queue_write(($urandom_range(0, 19) == 0) ? AXIS_NONE
                                                         : AXIS_W'($urandom_range(0, 2)),
                            POW_W'($urandom),
                            pick_coeff(coeff_style_t'($urandom_range(0, 2))));
                n++;
            end else begin
                queue_eval(ORD_W'($urandom_range(0, 4)), pick_time());
                n++;
            end
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin : drv_proc
        traj_beat_t cur_beat;
        traj_beat_t nxt;
        int         gap_left;
        bit         nv;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) absorb_beat(cur_beat);
            nv = s_valid && !s_ready;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_beats.size() > 0 &&
                             !(stim_beats[0].drain && pending_samples.size() > 0)) begin
                    nxt = stim_beats.pop_front();
                    s_mode        <= nxt.mode;
                    s_deriv_order <= nxt.order;
                    s_time_value  <= nxt.tval;
                    s_axis_sel    <= nxt.axis;
                    s_power_index <= nxt.power;
                    s_coeff_value <= nxt.coeff;
                    cur_beat = nxt;
                    gap_left = nxt.gap;
                    nv       = 1'b1;
                end
            end
            s_valid <= nv;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin : mon_proc
        traj_sample_t exp_s;
        int           stall_left;
        int           hold_left;
        bit           rx_idle;
        bit           rdy;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            rx_idle    = 1'b1;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    $error("result beat with nothing expected: x %0d y %0d z %0d sat %0b",
                           m_x_value, m_y_value, m_z_value, m_saturated);
                    err_cnt++;
                end else begin
                    exp_s = pending_samples.pop_front();
                    if (m_x_value !== exp_s.x) begin
                        $error("x_value: expected %0d, got %0d", exp_s.x, m_x_value);
                        err_cnt++;
                    end
                    if (m_y_value !== exp_s.y) begin
                        $error("y_value: expected %0d, got %0d", exp_s.y, m_y_value);
                        err_cnt++;
                    end
                    if (m_z_value !== exp_s.z) begin
                        $error("z_value: expected %0d, got %0d", exp_s.z, m_z_value);
                        err_cnt++;
                    end
                    if (m_saturated !== exp_s.sat) begin
                        $error("saturated: expected %0b, got %0b", exp_s.sat, m_saturated);
                        err_cnt++;
                    end
                end
                results_seen++;
                if (results_seen % IDLE_SPAN == 0) rx_idle = !rx_idle;
                stall_left = rx_idle ? $urandom_range(0, 6) : 0;
                // long back-pressure so the input queue fills and s_ready drops
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int p = 0; p < POW_SLOTS; p++) coeff_mem[a][p] = '0;
        end
        build_stimulus();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (stim_beats.size() > 0 || s_valid) @(posedge aclk);
        while (pending_samples.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_samples.size() > 0) begin
            $error("%0d results never arrived", pending_samples.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 500000);
        $error("timeout: %0d results still expected", pending_samples.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
